### hdl/afc_pkg.sv
// Shared types and constants for the acknowledge frame checker.
package afc_pkg;

  localparam logic [3:0] POS_HDR0    = 4'd0;
  localparam logic [3:0] POS_ID      = 4'd6;
  localparam logic [3:0] POS_LEN_HI  = 4'd7;
  localparam logic [3:0] POS_LEN_LO  = 4'd8;
  localparam logic [3:0] POS_CODE    = 4'd9;
  localparam logic [3:0] POS_PAYLOAD = 4'd10;
  localparam logic [3:0] POS_SUM_HI  = 4'd11;
  localparam logic [3:0] POS_SUM_LO  = 4'd12;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;

  localparam logic [1:0] STAT_GOOD    = 2'd0;
  localparam logic [1:0] STAT_SUM_BAD = 2'd1;
  localparam logic [1:0] STAT_LEN_BAD = 2'd2;

  localparam logic [7:0]  CODE_BAD        = 8'hFF;
  localparam logic [15:0] LEN_OVERHEAD    = 16'd3;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [7:0] result_code;
    logic [1:0] frame_status;
    logic       last;
  } afc_result_t;

endpackage

### hdl/module_ack_frame_checker_core.sv
// Acknowledge frame parser with 16-bit sum checksum check and payload pass-through.
// A result item is registered into the output stage when its byte is accepted.
// Throughput: one byte per cycle; a two-entry output stage (register plus skid)
// lets input continue while one result waits, input stalls only when both are full.
// Reset (synchronous): parser expects header byte one, max_payload_len is 4,
// no result pending.
module module_ack_frame_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  result_code,
  output logic [1:0]  frame_status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import afc_pkg::*;

  logic [15:0] max_payload_len;

  logic [3:0]  byte_position;
  logic [15:0] frame_length;
  logic [15:0] payload_left;
  logic [15:0] running_sum;
  logic [7:0]  confirm_code;
  logic [7:0]  checksum_high;
  logic        length_bad;

  logic [3:0]  pos_cur;
  logic [15:0] len_cur;
  logic [15:0] left_cur;
  logic [15:0] sum_cur;
  logic [7:0]  code_cur;
  logic [7:0]  chi_cur;
  logic        bad_cur;

  logic [3:0]  byte_position_next;
  logic [15:0] frame_length_next;
  logic [15:0] payload_left_next;
  logic [15:0] running_sum_next;
  logic [7:0]  confirm_code_next;
  logic [7:0]  checksum_high_next;
  logic        length_bad_next;

  logic [15:0] sum_add;
  logic [15:0] len_new;
  logic [15:0] got_sum;
  logic        has_res;
  afc_result_t res;

  afc_result_t out_item;
  afc_result_t skid_item;
  logic        skid_valid;
  logic        accept;
  logic        push;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;
  assign push      = accept && has_res;
  assign take      = out_valid && out_ready;

  always_comb begin
    pos_cur  = byte_position;
    len_cur  = frame_length;
    left_cur = payload_left;
    sum_cur  = running_sum;
    code_cur = confirm_code;
    chi_cur  = checksum_high;
    bad_cur  = length_bad;
    if (restart || byte_position > POS_SUM_LO) begin
      pos_cur  = POS_HDR0;
      len_cur  = '0;
      left_cur = '0;
      sum_cur  = '0;
      code_cur = '0;
      chi_cur  = '0;
      bad_cur  = 1'b0;
    end

    sum_add = sum_cur + {8'h00, rx_byte};
    len_new = {len_cur[15:8], rx_byte};
    got_sum = {chi_cur, rx_byte};

    byte_position_next = pos_cur;
    frame_length_next  = len_cur;
    payload_left_next  = left_cur;
    running_sum_next   = sum_cur;
    confirm_code_next  = code_cur;
    checksum_high_next = chi_cur;
    length_bad_next    = bad_cur;
    has_res            = 1'b0;
    res                = '0;

    unique case (pos_cur)
      POS_ID: begin
        running_sum_next   = sum_add;
        byte_position_next = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        running_sum_next   = sum_add;
        frame_length_next  = {rx_byte, 8'h00};
        byte_position_next = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        running_sum_next   = sum_add;
        frame_length_next  = len_new;
        length_bad_next    = (len_new < LEN_OVERHEAD) ||
                             ({1'b0, len_new} >
                              ({1'b0, max_payload_len} + {1'b0, LEN_OVERHEAD}));
        payload_left_next  = (len_new < LEN_OVERHEAD) ? 16'd0 : len_new - LEN_OVERHEAD;
        byte_position_next = POS_CODE;
      end
      POS_CODE: begin
        running_sum_next   = sum_add;
        confirm_code_next  = rx_byte;
        byte_position_next = (left_cur != 16'd0) ? POS_PAYLOAD : POS_SUM_HI;
      end
      POS_PAYLOAD: begin
        running_sum_next  = sum_add;
        payload_left_next = left_cur - 16'd1;
        if (left_cur == 16'd1) begin
          byte_position_next = POS_SUM_HI;
        end
        if (!bad_cur) begin
          has_res          = 1'b1;
          res.item_kind    = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end
      POS_SUM_HI: begin
        checksum_high_next = rx_byte;
        byte_position_next = POS_SUM_LO;
      end
      POS_SUM_LO: begin
        has_res       = 1'b1;
        res.item_kind = KIND_STATUS;
        res.last      = 1'b1;
        if (bad_cur) begin
          res.frame_status = STAT_LEN_BAD;
          res.result_code  = CODE_BAD;
        end else if (got_sum != sum_cur) begin
          res.frame_status = STAT_SUM_BAD;
          res.result_code  = CODE_BAD;
        end else begin
          res.frame_status = STAT_GOOD;
          res.result_code  = code_cur;
        end
        byte_position_next = POS_HDR0;
        frame_length_next  = '0;
        payload_left_next  = '0;
        running_sum_next   = '0;
        confirm_code_next  = '0;
        checksum_high_next = '0;
        length_bad_next    = 1'b0;
      end
      default: begin
        byte_position_next = pos_cur + 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HDR0;
      frame_length  <= '0;
      payload_left  <= '0;
      running_sum   <= '0;
      confirm_code  <= '0;
      checksum_high <= '0;
      length_bad    <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      payload_left  <= payload_left_next;
      running_sum   <= running_sum_next;
      confirm_code  <= confirm_code_next;
      checksum_high <= checksum_high_next;
      length_bad    <= length_bad_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_item <= skid_item;
        if (push) begin
          skid_item <= res;
        end
      end else if (push) begin
        out_item <= res;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_item <= res;
      end
    end else if (push) begin
      skid_item <= res;
    end
  end

  assign item_kind    = out_item.item_kind;
  assign payload_byte = out_item.payload_byte;
  assign result_code  = out_item.result_code;
  assign frame_status = out_item.frame_status;
  assign last         = out_item.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_SUM_LO)
    else $error("byte position out of range");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.last == out_item.item_kind))
    else $error("last flag disagrees with item kind");

  a_bad_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.item_kind == KIND_STATUS && out_item.frame_status != STAT_GOOD)
    |-> (out_item.result_code == CODE_BAD))
    else $error("bad frame without bad result code");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart && byte_position == POS_SUM_LO) |=> (byte_position == POS_HDR0))
    else $error("parser not back at header after frame end");

endmodule

### tb/sv/tb_module_ack_frame_checker_core.sv
// Testbench for the acknowledge frame checker: directed and random frames against a predictor.
`timescale 1ns / 1ps

module tb_module_ack_frame_checker_core;
  import afc_pkg::*;

  localparam int PHASE_BYTES = 200;
  localparam int SETTLE_CYCLES = 4;

  localparam afc_result_t NO_RES  = '0;
  localparam afc_result_t PAY_FF  = '{KIND_PAYLOAD, 8'hFF, 8'h00, STAT_GOOD, 1'b0};
  localparam afc_result_t GOOD_00 = '{KIND_STATUS, 8'h00, 8'h00, STAT_GOOD, 1'b1};
  localparam afc_result_t LEN_BAD = '{KIND_STATUS, 8'h00, CODE_BAD, STAT_LEN_BAD, 1'b1};

  typedef struct {
    logic [7:0]  b;
    logic        rs;
    bit          typed;
    afc_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        restart;
  logic        out_valid;
  logic        out_ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  result_code;
  logic [1:0]  frame_status;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  module_ack_frame_checker_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .payload_byte (payload_byte),
    .result_code  (result_code),
    .frame_status (frame_status),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // predictor state
  logic [3:0]  ps_pos;
  logic [15:0] ps_len;
  logic [15:0] ps_left;
  logic [15:0] ps_sum;
  logic [7:0]  ps_code;
  logic [7:0]  ps_sum_hi;
  logic        ps_len_bad;
  logic [15:0] max_payload;

  afc_result_t pending_results[$];
  dir_row_t    dir_rows[0:24];

  int  n_fail = 0;
  int  n_bytes = 0;
  int  n_frames = 0;
  int  n_payload = 0;
  int  n_status = 0;
  int  n_cfg = 0;
  bit  in_calm = 1'b0;
  bit  force_restart = 1'b0;
  bit  big_frame = 1'b0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #16_000_000;
    $display("Timeout with %0d result items outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic note_fail(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%s", msg);
  endtask

  task automatic clear_parser();
    ps_pos     = POS_HDR0;
    ps_len     = '0;
    ps_left    = '0;
    ps_sum     = '0;
    ps_code    = '0;
    ps_sum_hi  = '0;
    ps_len_bad = 1'b0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, input logic rs,
                               output bit emits, output afc_result_t res);
    logic [15:0] got_sum;
    emits = 1'b0;
    res = NO_RES;
    if (rs || ps_pos > POS_SUM_LO) clear_parser();
    case (ps_pos)
      POS_ID: begin
        ps_sum = ps_sum + {8'h00, b};
        ps_pos = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        ps_sum = ps_sum + {8'h00, b};
        ps_len = {b, 8'h00};
        ps_pos = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        ps_sum = ps_sum + {8'h00, b};
        ps_len = {ps_len[15:8], b};
        ps_len_bad = (ps_len < LEN_OVERHEAD) ||
                     ({1'b0, ps_len} > {1'b0, max_payload} + 17'd3);
        ps_left = (ps_len < LEN_OVERHEAD) ? 16'd0 : ps_len - LEN_OVERHEAD;
        ps_pos = POS_CODE;
      end
      POS_CODE: begin
        ps_sum = ps_sum + {8'h00, b};
        ps_code = b;
        ps_pos = (ps_left != 0) ? POS_PAYLOAD : POS_SUM_HI;
      end
      POS_PAYLOAD: begin
        ps_sum = ps_sum + {8'h00, b};
        ps_left = ps_left - 16'd1;
        if (ps_left == 0) ps_pos = POS_SUM_HI;
        if (!ps_len_bad) begin
          emits = 1'b1;
          res.item_kind = KIND_PAYLOAD;
          res.payload_byte = b;
        end
      end
      POS_SUM_HI: begin
        ps_sum_hi = b;
        ps_pos = POS_SUM_LO;
      end
      POS_SUM_LO: begin
        got_sum = {ps_sum_hi, b};
        emits = 1'b1;
        res.item_kind = KIND_STATUS;
        res.last = 1'b1;
        if (ps_len_bad) begin
          res.frame_status = STAT_LEN_BAD;
          res.result_code = CODE_BAD;
        end else if (got_sum != ps_sum) begin
          res.frame_status = STAT_SUM_BAD;
          res.result_code = CODE_BAD;
        end else begin
          res.frame_status = STAT_GOOD;
          res.result_code = ps_code;
        end
        clear_parser();
      end
      default: begin
        ps_pos = ps_pos + 4'd1;
      end
    endcase
  endtask

  // entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic rs, input bit typed,
                           input afc_result_t typed_res);
    int gap;
    bit emits;
    afc_result_t res;
    if (n_bytes % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(b, rs, emits, res);
    if (typed) pending_results.push_back(typed_res);
    else if (emits) pending_results.push_back(res);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    max_payload = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_frame();
    logic [7:0]  fb[$];
    logic [15:0] flen;
    logic [15:0] fsum;
    int kind;
    int n;
    int cut;
    logic rs;
    kind = $urandom_range(0, 99);
    rs = force_restart ? 1'b1 : 1'($urandom_range(0, 1));
    if (kind >= 94) begin
      // line noise, then resynchronise
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, NO_RES);
      force_restart = 1'b1;
      return;
    end
    n = $urandom_range(0, (max_payload < 8) ? int'(max_payload) : 8);
    flen = 16'(n + 3);
    if (kind >= 80 && kind < 88) begin
      if (max_payload <= 30 && $urandom_range(0, 1) == 1)
        flen = max_payload + 16'd4 + 16'($urandom_range(0, 4));
      else
        flen = 16'($urandom_range(0, 2));
    end else if (big_frame) begin
      flen = 16'($urandom_range(256, 300) + 3);
      big_frame = 1'b0;
    end
    for (int i = 0; i < 6; i++) fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(flen[15:8]);
    fb.push_back(flen[7:0]);
    fb.push_back(8'($urandom));
    n = (flen < LEN_OVERHEAD) ? 0 : int'(flen - LEN_OVERHEAD);
    for (int i = 0; i < n; i++) fb.push_back(8'($urandom));
    fsum = '0;
    for (int i = 6; i < fb.size(); i++) fsum = fsum + {8'h00, fb[i]};
    if (kind >= 70 && kind < 80) fsum = fsum ^ 16'($urandom_range(1, 65535));
    fb.push_back(fsum[15:8]);
    fb.push_back(fsum[7:0]);
    cut = fb.size();
    force_restart = 1'b0;
    if (kind >= 88) begin
      cut = $urandom_range(1, fb.size() - 1);
      force_restart = 1'b1;
    end else begin
      n_frames++;
    end
    for (int i = 0; i < cut; i++) send_byte(fb[i], (i == 0) ? rs : 1'b0, 1'b0, NO_RES);
  endtask

  // result side back-pressure
  initial begin : result_drain
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_watch
    afc_result_t seen;
    afc_result_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{item_kind, payload_byte, result_code, frame_status, last};
      if (seen.item_kind == KIND_STATUS) n_status++;
      else n_payload++;
      if (pending_results.size() == 0) begin
        note_fail($sformatf("Unexpected result: kind %0b byte %02h code %02h stat %0d last %0b",
                            seen.item_kind, seen.payload_byte, seen.result_code,
                            seen.frame_status, seen.last));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want)
          note_fail($sformatf({"Mismatch: kind %0b/%0b byte %02h/%02h code %02h/%02h ",
                               "stat %0d/%0d last %0b/%0b (expected/actual)"},
                              want.item_kind, seen.item_kind,
                              want.payload_byte, seen.payload_byte,
                              want.result_code, seen.result_code,
                              want.frame_status, seen.frame_status,
                              want.last, seen.last));
      end
    end
  end

  initial begin : stimulus
    logic [15:0] phase_max[7];
    int phase_end;
    int guard;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    restart = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    max_payload = MAX_PAYLOAD_RST;
    clear_parser();

    // good frame with restart, then a back-to-back frame with a short length
    dir_rows = '{
      '{8'h00, 1'b1, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h04, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b1, PAY_FF}, '{8'h02, 1'b0, 1'b0, NO_RES},
      '{8'h02, 1'b0, 1'b1, GOOD_00},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h55, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hAA, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b1, LEN_BAD}
    };
    phase_max = '{16'd0, 16'd65532, 16'd1, 16'd12, 16'd0, 16'd4, 16'd0};
    phase_max[4] = 16'($urandom_range(2, 40));
    phase_max[6] = 16'($urandom_range(5, 20));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 25; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].rs, dir_rows[i].typed, dir_rows[i].res);
      if (dir_rows[i].typed) n_frames += dir_rows[i].res.last;
    end

    for (int p = 0; p < 7; p++) begin
      write_max_payload(phase_max[p]);
      big_frame = (phase_max[p] == 16'd65532);
      force_restart = 1'b1;
      phase_end = n_bytes + PHASE_BYTES;
      while (n_bytes < phase_end) send_random_frame();
    end

    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (pending_results.size() != 0)
      note_fail($sformatf("%0d expected result items never arrived",
                          pending_results.size()));

    $display("Covered %0d bytes, %0d whole frames plus cut frames and noise, %0d length limits",
             n_bytes, n_frames, n_cfg + 1);
    $display("Checked %0d payload items and %0d frame status items, %0d failures",
             n_payload, n_status, n_fail);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
hdl/afc_pkg.sv
hdl/module_ack_frame_checker_core.sv
tb/sv/tb_module_ack_frame_checker_core.sv
